// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile
// every check away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: rtl/dgps_pkg.sv
// ----------------------------------------------------------------------------
// dgps_pkg
// Types, codes and helpers of the dwell gated phase sequencer.
// ----------------------------------------------------------------------------
package dgps_pkg;

    // Default depth of the phase table
    localparam int MAX_PHASES_DEF = 8;

    // Field widths
    localparam int OP_W    = 3;
    localparam int TEMP_W  = 12;
    localparam int MS_W    = 16;
    localparam int SLOT_W  = 3;
    localparam int MODE_W  = 2;
    localparam int SEC_W   = 16;
    localparam int CNT_W   = 4;
    localparam int TOL_W   = 11;
    localparam int STAT_W  = 2;
    localparam int ESEC_W  = 7;
    localparam int REM_W   = 10;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Millisecond split: q = (ms * RECIP) >> RECIP_SH is exact for 16-bit ms
    localparam int MS_PER_SEC = 1000;
    localparam int RECIP      = 67109;
    localparam int RECIP_SH   = 26;
    localparam int PROD_W     = MS_W + 17;

    localparam logic [SEC_W-1:0] SEC_MAX = '1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd4;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd5;

    // Session status codes
    localparam logic [STAT_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RUN   = 2'd1;
    localparam logic [STAT_W-1:0] ST_PAUSE = 2'd2;
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd3;

    // Drive modes
    localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;

    // Register indexes (word address)
    localparam logic [1:0] REG_PHASE_COUNT = 2'd0;
    localparam logic [1:0] REG_TOLERANCE   = 2'd1;
    localparam logic [1:0] REG_IDLE_TARGET = 2'd2;

    // Register reset values
    localparam logic [CNT_W-1:0]         RST_PHASE_COUNT = 4'd0;
    localparam logic [TOL_W-1:0]         RST_TOLERANCE   = 11'd16;
    localparam logic signed [TEMP_W-1:0] RST_IDLE_TARGET = 12'sd384;

    // One phase table entry
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [TEMP_W-1:0]  target;
        logic [SEC_W-1:0]          seconds;
    } t_entry;

    // Configuration register values
    typedef struct packed {
        logic [CNT_W-1:0]          phase_count;
        logic [TOL_W-1:0]          tolerance;
        logic signed [TEMP_W-1:0]  idle_target;
    } t_cfg;

    // Registered input item, elapsed time already split into sec and ms
    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic signed [TEMP_W-1:0]  temp;
        logic [ESEC_W-1:0]         esec;
        logic [REM_W-1:0]          erem;
        logic [SLOT_W-1:0]         slot;
        t_entry                    entry;
    } t_item;

    // Timer kept as whole seconds (saturating) plus leftover milliseconds
    typedef struct packed {
        logic [SEC_W-1:0]          sec;
        logic [REM_W-1:0]          rem;
    } t_timer;

    // Add a split millisecond amount to a timer, saturate the seconds
    function automatic t_timer timer_add(input t_timer t,
                                         input logic [ESEC_W-1:0] esec,
                                         input logic [REM_W-1:0] erem);
        logic [REM_W:0]   rem_sum;
        logic             carry;
        logic [SEC_W:0]   sec_sum;
        t_timer           res;
        rem_sum = {1'b0, t.rem} + {1'b0, erem};
        carry   = (rem_sum >= (REM_W+1)'(MS_PER_SEC));
        res.rem = carry ? REM_W'(rem_sum - (REM_W+1)'(MS_PER_SEC)) : REM_W'(rem_sum);
        sec_sum = {1'b0, t.sec} + (SEC_W+1)'(esec) + (SEC_W+1)'(carry);
        res.sec = sec_sum[SEC_W] ? SEC_MAX : sec_sum[SEC_W-1:0];
        return res;
    endfunction

endpackage

// File: rtl/dgps_cfg_regs.sv
// ----------------------------------------------------------------------------
// dgps_cfg_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module dgps_cfg_regs #(
    parameter int MAX_PHASES = dgps_pkg::MAX_PHASES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dgps_pkg::PADDR_W-1:0]  paddr,
    input  logic [dgps_pkg::PDATA_W-1:0]  pwdata,
    output logic [dgps_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output dgps_pkg::t_cfg                o_cfg
);

    dgps_pkg::t_cfg                 r_cfg;
    logic                           w_wr;
    logic [1:0]                     w_idx;
    logic [dgps_pkg::CNT_W-1:0]     w_count;

    assign w_wr    = psel && penable && pwrite && pready;
    assign w_idx   = paddr[3:2];
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Clamp the phase count to the table depth
    assign w_count = (32'(pwdata[dgps_pkg::CNT_W-1:0]) > MAX_PHASES) ?
                     dgps_pkg::CNT_W'(MAX_PHASES) : pwdata[dgps_pkg::CNT_W-1:0];

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_count <= dgps_pkg::RST_PHASE_COUNT;
            r_cfg.tolerance   <= dgps_pkg::RST_TOLERANCE;
            r_cfg.idle_target <= dgps_pkg::RST_IDLE_TARGET;
        end else if (w_wr) begin
            case (w_idx)
                dgps_pkg::REG_PHASE_COUNT: r_cfg.phase_count <= w_count;
                dgps_pkg::REG_TOLERANCE:
                    r_cfg.tolerance <= pwdata[dgps_pkg::TOL_W-1:0];
                dgps_pkg::REG_IDLE_TARGET:
                    r_cfg.idle_target <= $signed(pwdata[dgps_pkg::TEMP_W-1:0]);
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            dgps_pkg::REG_PHASE_COUNT: prdata = dgps_pkg::PDATA_W'(r_cfg.phase_count);
            dgps_pkg::REG_TOLERANCE:   prdata = dgps_pkg::PDATA_W'(r_cfg.tolerance);
            dgps_pkg::REG_IDLE_TARGET:
                prdata = {{(dgps_pkg::PDATA_W-dgps_pkg::TEMP_W){r_cfg.idle_target[11]}},
                          r_cfg.idle_target};
            default:                   prdata = '0;
        endcase
    end

endmodule

// File: rtl/dgps_in_stage.sv
// ----------------------------------------------------------------------------
// dgps_in_stage
// Input register. Splits the elapsed milliseconds into seconds and leftover
// milliseconds on the way in.
// ----------------------------------------------------------------------------
module dgps_in_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dgps_pkg::OP_W-1:0]           i_operation,
    input  logic signed [dgps_pkg::TEMP_W-1:0]  i_temperature,
    input  logic [dgps_pkg::MS_W-1:0]           i_elapsed_ms,
    input  logic [dgps_pkg::SLOT_W-1:0]         i_entry_slot,
    input  logic [dgps_pkg::MODE_W-1:0]         i_entry_mode,
    input  logic signed [dgps_pkg::TEMP_W-1:0]  i_entry_target,
    input  logic [dgps_pkg::SEC_W-1:0]          i_entry_seconds,
    input  logic                                i_take,
    output logic                                o_item_valid,
    output dgps_pkg::t_item                     o_item
);

    logic                               r_valid;
    dgps_pkg::t_item                    r_item;
    logic                               w_accept;
    logic [dgps_pkg::PROD_W-1:0]        w_prod;
    logic [dgps_pkg::ESEC_W-1:0]        w_esec;
    logic [dgps_pkg::MS_W:0]            w_esec_ms;
    logic [dgps_pkg::MS_W:0]            w_rem;

    assign o_in_stall   = r_valid && !i_take;
    assign w_accept     = i_in_valid && !o_in_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // Divide by 1000 through the reciprocal, rebuild q*1000 by shifts
    assign w_prod    = dgps_pkg::PROD_W'(i_elapsed_ms) * dgps_pkg::PROD_W'(dgps_pkg::RECIP);
    assign w_esec    = w_prod[dgps_pkg::RECIP_SH +: dgps_pkg::ESEC_W];
    assign w_esec_ms = (dgps_pkg::MS_W+1)'({w_esec, 10'b0})
                     - (dgps_pkg::MS_W+1)'({w_esec, 4'b0})
                     - (dgps_pkg::MS_W+1)'({w_esec, 3'b0});
    assign w_rem     = {1'b0, i_elapsed_ms} - w_esec_ms;

    // Hold the item until the core takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.op            <= i_operation;
            r_item.temp          <= i_temperature;
            r_item.esec          <= w_esec;
            r_item.erem          <= w_rem[dgps_pkg::REM_W-1:0];
            r_item.slot          <= i_entry_slot;
            r_item.entry.mode    <= i_entry_mode;
            r_item.entry.target  <= i_entry_target;
            r_item.entry.seconds <= i_entry_seconds;
        end
    end

endmodule

// File: rtl/dgps_seq_core.sv
// ----------------------------------------------------------------------------
// dgps_seq_core
// Session state, phase table and dwell timers; one item per cycle, while the
// output is not stalled, updates them and leaves its result in the output register.
// ----------------------------------------------------------------------------
module dgps_seq_core #(
    parameter int MAX_PHASES = dgps_pkg::MAX_PHASES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_item_valid,
    input  dgps_pkg::t_item                     i_item,
    output logic                                o_take,
    input  dgps_pkg::t_cfg                      i_cfg,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [dgps_pkg::TEMP_W-1:0]  o_target_temp,
    output logic [dgps_pkg::MODE_W-1:0]         o_drive_mode,
    output logic [dgps_pkg::STAT_W-1:0]         o_session_status,
    output logic [dgps_pkg::CNT_W-1:0]          o_current_phase,
    output logic                                o_in_tolerance,
    output logic                                o_phase_advanced,
    output logic [dgps_pkg::SEC_W-1:0]          o_total_dwell_sec,
    output logic [dgps_pkg::SEC_W-1:0]          o_phase_dwell_sec,
    output logic [dgps_pkg::SEC_W-1:0]          o_session_elapsed_sec
);

    localparam int IDX_W     = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
    localparam int TAB_DEPTH = 2 ** IDX_W;

    // Session state
    logic [dgps_pkg::STAT_W-1:0]    r_state, n_state;
    logic [dgps_pkg::CNT_W-1:0]     r_ptr, n_ptr, w_ptr_eff;
    dgps_pkg::t_timer               r_phase, n_phase;
    dgps_pkg::t_timer               r_total, n_total;
    dgps_pkg::t_timer               r_sess, n_sess;
    logic                           r_started, n_started;

    // Phase table and prefetched entries
    dgps_pkg::t_entry               r_phase_tab [TAB_DEPTH];
    dgps_pkg::t_entry               r_cur;
    dgps_pkg::t_entry               r_nxt;
    dgps_pkg::t_entry               r_first;
    dgps_pkg::t_entry               w_sel;
    logic [IDX_W-1:0]               w_rd_cur, w_rd_nxt, w_wr_idx;
    logic                           w_tab_wr, w_tab_wr_en;

    // Result register
    logic                           r_out_valid;
    logic signed [dgps_pkg::TEMP_W-1:0] r_target;
    logic [dgps_pkg::MODE_W-1:0]    r_mode;
    logic                           r_counted, r_advanced;

    logic                           w_slot_ok;
    logic                           w_counted, w_advanced, w_start_hit, w_show;
    logic signed [dgps_pkg::TEMP_W:0] w_err;
    logic [dgps_pkg::TEMP_W:0]      w_abs;
    logic                           w_in_tol;

    function automatic logic ptr_ok(input logic [dgps_pkg::CNT_W-1:0] p,
                                    input logic [dgps_pkg::CNT_W-1:0] cnt);
        return (p < cnt) && (32'(p) < MAX_PHASES);
    endfunction

    assign o_take      = i_item_valid && (!r_out_valid || !i_out_stall);
    assign w_slot_ok   = 32'(i_item.slot) < MAX_PHASES;
    assign w_tab_wr_en = o_take && w_tab_wr;
    assign w_wr_idx    = IDX_W'(i_item.slot);

    // Temperature error against the active phase target
    assign w_err    = $signed({i_item.temp[dgps_pkg::TEMP_W-1], i_item.temp})
                    - $signed({r_cur.target[dgps_pkg::TEMP_W-1], r_cur.target});
    assign w_abs    = w_err[dgps_pkg::TEMP_W] ? (dgps_pkg::TEMP_W+1)'(-w_err)
                                              : (dgps_pkg::TEMP_W+1)'(w_err);
    assign w_in_tol = w_abs <= (dgps_pkg::TEMP_W+1)'(i_cfg.tolerance);

    // Next session state for the item in the input register
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_phase     = r_phase;
        n_total     = r_total;
        n_sess      = r_sess;
        n_started   = r_started;
        w_counted   = 1'b0;
        w_advanced  = 1'b0;
        w_start_hit = 1'b0;
        w_tab_wr    = 1'b0;
        case (i_item.op)
            dgps_pkg::OP_TICK: begin
                if (r_started) begin
                    n_sess = dgps_pkg::timer_add(r_sess, i_item.esec, i_item.erem);
                end
                if (r_state == dgps_pkg::ST_RUN) begin
                    if (!ptr_ok(r_ptr, i_cfg.phase_count)) begin
                        n_state = dgps_pkg::ST_DONE;
                    end else begin
                        if (w_in_tol) begin
                            w_counted = 1'b1;
                            n_phase = dgps_pkg::timer_add(r_phase, i_item.esec, i_item.erem);
                            n_total = dgps_pkg::timer_add(r_total, i_item.esec, i_item.erem);
                        end
                        // Advance once the phase has dwelt long enough
                        if (n_phase.sec >= r_cur.seconds) begin
                            w_advanced = 1'b1;
                            n_ptr      = r_ptr + dgps_pkg::CNT_W'(1);
                            n_phase    = '0;
                            if (!ptr_ok(n_ptr, i_cfg.phase_count)) begin
                                n_state = dgps_pkg::ST_DONE;
                            end
                        end
                    end
                end
            end
            dgps_pkg::OP_START: begin
                if (i_cfg.phase_count != '0) begin
                    n_state     = dgps_pkg::ST_RUN;
                    n_ptr       = '0;
                    n_phase     = '0;
                    n_total     = '0;
                    n_sess      = '0;
                    n_started   = 1'b1;
                    w_start_hit = 1'b1;
                end
            end
            dgps_pkg::OP_STOP: begin
                n_state = dgps_pkg::ST_IDLE;
            end
            dgps_pkg::OP_PAUSE: begin
                if (r_state == dgps_pkg::ST_RUN) begin
                    n_state = dgps_pkg::ST_PAUSE;
                end
            end
            dgps_pkg::OP_RESUME: begin
                if (r_state == dgps_pkg::ST_PAUSE) begin
                    n_state = dgps_pkg::ST_RUN;
                end
            end
            dgps_pkg::OP_WRITE: begin
                if (w_slot_ok) begin
                    w_tab_wr = 1'b1;
                    n_state  = dgps_pkg::ST_IDLE;
                    n_ptr    = '0;
                end
            end
            default: ;
        endcase
    end

    // Pick the entry that the new pointer names
    assign w_sel  = w_start_hit ? r_first : (w_advanced ? r_nxt : r_cur);
    assign w_show = (n_state == dgps_pkg::ST_RUN) && ptr_ok(n_ptr, i_cfg.phase_count);

    // Advance session state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dgps_pkg::ST_IDLE;
            r_ptr     <= '0;
            r_phase   <= '0;
            r_total   <= '0;
            r_sess    <= '0;
            r_started <= 1'b0;
        end else if (o_take) begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_phase   <= n_phase;
            r_total   <= n_total;
            r_sess    <= n_sess;
            r_started <= n_started;
        end
    end

    // Table write and prefetch of the current and following entries
    assign w_ptr_eff = o_take ? n_ptr : r_ptr;
    assign w_rd_cur  = IDX_W'(w_ptr_eff);
    assign w_rd_nxt  = IDX_W'(w_ptr_eff + dgps_pkg::CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (w_tab_wr_en) begin
            r_phase_tab[w_wr_idx] <= i_item.entry;
        end
        r_cur <= (w_tab_wr_en && (w_wr_idx == w_rd_cur)) ? i_item.entry
                                                          : r_phase_tab[w_rd_cur];
        r_nxt <= (w_tab_wr_en && (w_wr_idx == w_rd_nxt)) ? i_item.entry
                                                          : r_phase_tab[w_rd_nxt];
        if (w_tab_wr_en && (i_item.slot == '0)) begin
            r_first <= i_item.entry;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_target   <= w_show ? w_sel.target : i_cfg.idle_target;
            r_mode     <= w_show ? w_sel.mode : dgps_pkg::MODE_OFF;
            r_counted  <= w_counted;
            r_advanced <= w_advanced;
        end
    end

    // Status and timers follow the state registers, which only move on take
    assign o_out_valid           = r_out_valid;
    assign o_target_temp         = r_target;
    assign o_drive_mode          = r_mode;
    assign o_session_status      = r_state;
    assign o_current_phase       = r_ptr;
    assign o_in_tolerance        = r_counted;
    assign o_phase_advanced      = r_advanced;
    assign o_total_dwell_sec     = r_total.sec;
    assign o_phase_dwell_sec     = r_phase.sec;
    assign o_session_elapsed_sec = r_sess.sec;

endmodule

// File: rtl/dwell_gated_phase_sequencer_unit.sv
// ----------------------------------------------------------------------------
// dwell_gated_phase_sequencer_unit
// Steps a session through a table of heat and cool phases. A tick counts its
// elapsed milliseconds toward the phase and total dwell only while the
// measured temperature is within tolerance of the phase target; a phase ends
// once its dwell reaches its duration. The block takes one item every clock
// cycle while the output is not stalled. Each accepted item passes through the
// input register and then the single state update (tolerance check, timer
// add, duration compare) into the output register. Timers are kept as
// saturating seconds plus leftover milliseconds. The phase table needs no
// clearing after reset; entries must be written before a session uses them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dwell_gated_phase_sequencer_unit #(
    parameter int MAX_PHASES = dgps_pkg::MAX_PHASES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dgps_pkg::PADDR_W-1:0]        paddr,
    input  logic [dgps_pkg::PDATA_W-1:0]        pwdata,
    output logic [dgps_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    // Input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dgps_pkg::OP_W-1:0]           i_operation,
    input  logic signed [dgps_pkg::TEMP_W-1:0]  i_temperature,
    input  logic [dgps_pkg::MS_W-1:0]           i_elapsed_ms,
    input  logic [dgps_pkg::SLOT_W-1:0]         i_entry_slot,
    input  logic [dgps_pkg::MODE_W-1:0]         i_entry_mode,
    input  logic signed [dgps_pkg::TEMP_W-1:0]  i_entry_target,
    input  logic [dgps_pkg::SEC_W-1:0]          i_entry_seconds,
    // Result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [dgps_pkg::TEMP_W-1:0]  o_target_temp,
    output logic [dgps_pkg::MODE_W-1:0]         o_drive_mode,
    output logic [dgps_pkg::STAT_W-1:0]         o_session_status,
    output logic [dgps_pkg::CNT_W-1:0]          o_current_phase,
    output logic                                o_in_tolerance,
    output logic                                o_phase_advanced,
    output logic [dgps_pkg::SEC_W-1:0]          o_total_dwell_sec,
    output logic [dgps_pkg::SEC_W-1:0]          o_phase_dwell_sec,
    output logic [dgps_pkg::SEC_W-1:0]          o_session_elapsed_sec
);

    dgps_pkg::t_cfg     w_cfg;
    dgps_pkg::t_item    w_item;
    logic               w_item_valid;
    logic               w_take;

    // Configuration registers
    dgps_cfg_regs #(
        .MAX_PHASES (MAX_PHASES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input register
    dgps_in_stage u_in (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_temperature   (i_temperature),
        .i_elapsed_ms    (i_elapsed_ms),
        .i_entry_slot    (i_entry_slot),
        .i_entry_mode    (i_entry_mode),
        .i_entry_target  (i_entry_target),
        .i_entry_seconds (i_entry_seconds),
        .i_take          (w_take),
        .o_item_valid    (w_item_valid),
        .o_item          (w_item)
    );

    // Sequencer state and result register
    dgps_seq_core #(
        .MAX_PHASES (MAX_PHASES)
    ) u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_item_valid          (w_item_valid),
        .i_item                (w_item),
        .o_take                (w_take),
        .i_cfg                 (w_cfg),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_target_temp         (o_target_temp),
        .o_drive_mode          (o_drive_mode),
        .o_session_status      (o_session_status),
        .o_current_phase       (o_current_phase),
        .o_in_tolerance        (o_in_tolerance),
        .o_phase_advanced      (o_phase_advanced),
        .o_total_dwell_sec     (o_total_dwell_sec),
        .o_phase_dwell_sec     (o_phase_dwell_sec),
        .o_session_elapsed_sec (o_session_elapsed_sec)
    );

    // An accepted item always lands in the input register
    `ASSERT_NEXT(a_item_lands, i_clk, i_rst_n, i_in_valid && !o_in_stall, w_item_valid, "accepted item lost")

    // Drive is off whenever the session is not running
    `ASSERT_IMPLY(a_drive_off, i_clk, i_rst_n, o_out_valid && (o_session_status != dgps_pkg::ST_RUN), o_drive_mode == dgps_pkg::MODE_OFF, "drive active outside running")

    // A finished phase restarts its dwell timer
    `ASSERT_IMPLY(a_adv_clears, i_clk, i_rst_n, o_out_valid && o_phase_advanced, o_phase_dwell_sec == '0, "phase dwell not cleared on advance")

    // Counting happens only in a running session
    `ASSERT_IMPLY(a_count_run, i_clk, i_rst_n, o_out_valid && o_in_tolerance, (o_session_status == dgps_pkg::ST_RUN) || (o_session_status == dgps_pkg::ST_DONE), "dwell counted while not running")

    // The phase pointer never goes beyond the table depth
    `ASSERT_IMPLY(a_ptr_range, i_clk, i_rst_n, o_out_valid, 32'(o_current_phase) <= MAX_PHASES, "phase pointer beyond table")

endmodule
